// ===== rtl/candle_column_with_dual_sma_core_assert.svh =====
// ---------------------------------------------------------------------------
// Candle column with dual SMA: assertion macros
// Concurrent assertion helpers shared by the RTL files of this block.
// ---------------------------------------------------------------------------
`ifndef CANDLE_COLUMN_WITH_DUAL_SMA_CORE_ASSERT_SVH
`define CANDLE_COLUMN_WITH_DUAL_SMA_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CCSMA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCSMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CCSMA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define CCSMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/ccsma_pkg.sv =====
// ---------------------------------------------------------------------------
// Candle column with dual SMA: package
// Field widths, window defaults, controller states and the byte clamp.
// ---------------------------------------------------------------------------
package ccsma_pkg;

  localparam int LEVEL_W         = 16;
  localparam int BYTE_W          = 8;
  localparam int BYTE_MAX        = 255;
  localparam int QUOT_BITS       = 8;
  localparam int FAST_WINDOW_DEF = 10;
  localparam int SLOW_WINDOW_DEF = 20;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [BYTE_W-1:0]         byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_DONE
  } ccsma_state_t;

  // Saturate a signed level to the 0..255 range.
  function automatic byte_t clamp_byte(input level_t v);
    byte_t r;
    if (v[LEVEL_W-1]) begin
      r = '0;
    end else if (v > level_t'(BYTE_MAX)) begin
      r = '1;
    end else begin
      r = v[BYTE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ccsma_in_if.sv =====
// ---------------------------------------------------------------------------
// Candle column with dual SMA: input channel
// Valid/ready channel that carries one candle per request.
// ---------------------------------------------------------------------------
interface ccsma_in_if;

  logic                valid;
  logic                ready;
  ccsma_pkg::level_t   open_level;
  ccsma_pkg::level_t   high_level;
  ccsma_pkg::level_t   low_level;
  ccsma_pkg::level_t   close_level;

  modport source (
    output valid, open_level, high_level, low_level, close_level,
    input  ready
  );

  modport sink (
    input  valid, open_level, high_level, low_level, close_level,
    output ready
  );

endinterface

// ===== rtl/ccsma_out_if.sv =====
// ---------------------------------------------------------------------------
// Candle column with dual SMA: result channel
// Valid/ready channel that carries the clamped bytes and both averages.
// ---------------------------------------------------------------------------
interface ccsma_out_if;

  logic             valid;
  logic             ready;
  ccsma_pkg::byte_t high_byte;
  ccsma_pkg::byte_t low_byte;
  ccsma_pkg::byte_t open_byte;
  ccsma_pkg::byte_t close_byte;
  ccsma_pkg::byte_t fast_average;
  ccsma_pkg::byte_t slow_average;

  modport source (
    output valid, high_byte, low_byte, open_byte, close_byte, fast_average, slow_average,
    input  ready
  );

  modport sink (
    input  valid, high_byte, low_byte, open_byte, close_byte, fast_average, slow_average,
    output ready
  );

endinterface

// ===== rtl/ccsma_ram.sv =====
// ---------------------------------------------------------------------------
// Candle column with dual SMA: generic RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module ccsma_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 20,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ccsma_div.sv =====
// ---------------------------------------------------------------------------
// Candle column with dual SMA: saturating serial divider
// Restoring division that yields an 8-bit quotient, saturated at 255.
// ---------------------------------------------------------------------------
`include "candle_column_with_dual_sma_core_assert.svh"

module ccsma_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output ccsma_pkg::byte_t quot
);

  localparam int DW = NUM_W + ccsma_pkg::QUOT_BITS;
  localparam int IW = $clog2(ccsma_pkg::QUOT_BITS);

  logic             busy_r, busy_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  ccsma_pkg::byte_t q_r, q_nxt;

  logic [DW-1:0] den_ext, den_sh, den_top, num_ext, rem_ext, rem_sub;

  assign den_ext = DW'(den);
  assign den_sh  = den_ext << idx_r;
  assign den_top = den_ext << ccsma_pkg::QUOT_BITS;
  assign num_ext = DW'(num);
  assign rem_ext = DW'(rem_r);
  assign rem_sub = rem_ext - den_sh;

  // A quotient of 256 or more is settled at once; otherwise one bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      if (num_ext >= den_top) begin
        q_nxt    = '1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = num;
        idx_nxt  = IW'(ccsma_pkg::QUOT_BITS - 1);
        q_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem_ext >= den_sh) begin
        rem_nxt       = rem_sub[NUM_W-1:0];
        q_nxt[idx_r]  = 1'b1;
      end
      idx_nxt = idx_r - 1'b1;
      if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

  `CCSMA_ASSERT_NEXT(a_div_last_step, clk, rst_n, busy_r && (idx_r == '0) && !start, !busy_r, "divider did not stop after its last bit")
  `CCSMA_ASSERT_NEXT(a_div_start_idx, clk, rst_n, start, !busy_r || (idx_r == IW'(ccsma_pkg::QUOT_BITS - 1)), "divider started at a wrong bit")
  `CCSMA_ASSERT_NEXT(a_div_step, clk, rst_n, busy_r && !start && (idx_r != '0), busy_r && (idx_r == $past(idx_r) - 1'b1), "divider skipped a bit")

endmodule

// ===== rtl/candle_column_with_dual_sma_core.sv =====
// ---------------------------------------------------------------------------
// Candle column with dual SMA: top level
// Clamps one candle to bytes and forms a fast and a slow moving average of
// the positive closes, with the close history kept in a small RAM.
// ---------------------------------------------------------------------------
//
//   Channel   Modport  Request carries
//   --------  -------  -----------------------------------------------------
//   in_chan   sink     open_level, high_level, low_level, close_level (s16)
//   out_chan  source   high/low/open/close bytes, fast and slow average (u8)
//
// A candle goes through a sweep of the history RAM, one entry per cycle,
// and then through the 8-step serial divides; a divide ends at once when
// its quotient saturates, as both do for an empty window. HIST_DEPTH is
// the larger window and so sets the length of the sweep. Reset is
// synchronous and active low; a fill count empties the history, so no
// clearing pass runs. A stalled result waits in the output register while
// the next candle is taken and processed.
// ---------------------------------------------------------------------------
`include "candle_column_with_dual_sma_core_assert.svh"

module candle_column_with_dual_sma_core #(
  parameter int FAST_WINDOW = ccsma_pkg::FAST_WINDOW_DEF,
  parameter int SLOW_WINDOW = ccsma_pkg::SLOW_WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ccsma_in_if.sink     in_chan,
  ccsma_out_if.source  out_chan
);

  // The history is as deep as the larger window.
  localparam int HIST_DEPTH = (FAST_WINDOW > SLOW_WINDOW) ? FAST_WINDOW : SLOW_WINDOW;
  localparam int AW         = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  // Wide enough to hold HIST_DEPTH itself (positions and counts).
  localparam int KW         = $clog2(HIST_DEPTH + 1);
  // A sum of HIST_DEPTH positive 15-bit closes, with a spare bit.
  localparam int SUM_W      = 16 + $clog2(HIST_DEPTH);
  localparam int POS_W      = ccsma_pkg::LEVEL_W - 1;

  // Controller.
  ccsma_pkg::ccsma_state_t state_r, state_nxt;

  logic in_ready;
  logic in_accept;
  logic rd_en;
  logic div_start;
  logic out_load;

  // History bookkeeping. wptr_r is the slot the next close goes to; fill_r
  // counts slots written since reset, so older slots read as empty.
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [KW-1:0] fill_r, fill_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [KW-1:0] rd_k_r, rd_k_nxt;

  ccsma_pkg::level_t hist_data;
  logic              hist_pos;
  logic              hist_live;
  logic [SUM_W-1:0]  hist_val;

  // Accumulators for both windows.
  logic [SUM_W-1:0] sum_fast_r, sum_fast_nxt;
  logic [SUM_W-1:0] sum_slow_r, sum_slow_nxt;
  logic [KW-1:0]    cnt_fast_r, cnt_fast_nxt;
  logic [KW-1:0]    cnt_slow_r, cnt_slow_nxt;

  // The candle being processed.
  ccsma_pkg::level_t open_r, open_nxt;
  ccsma_pkg::level_t high_r, high_nxt;
  ccsma_pkg::level_t low_r, low_nxt;
  ccsma_pkg::level_t close_r, close_nxt;

  // Dividers.
  logic             fast_busy, slow_busy;
  ccsma_pkg::byte_t fast_q, slow_q;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  ccsma_pkg::byte_t high_byte_r, high_byte_nxt;
  ccsma_pkg::byte_t low_byte_r, low_byte_nxt;
  ccsma_pkg::byte_t open_byte_r, open_byte_nxt;
  ccsma_pkg::byte_t close_byte_r, close_byte_nxt;
  ccsma_pkg::byte_t fast_avg_r, fast_avg_nxt;
  ccsma_pkg::byte_t slow_avg_r, slow_avg_nxt;

  // -------------------------------------------------------------------------
  // Next state. The sweep reads one history slot per cycle, newest first,
  // and stays in ST_READ after the last read until it lands in the sums.
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccsma_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ccsma_pkg::ST_READ;
        end
      end
      ccsma_pkg::ST_READ: begin
        if (k_r == KW'(HIST_DEPTH)) begin
          state_nxt = ccsma_pkg::ST_START;
        end
      end
      ccsma_pkg::ST_START: begin
        state_nxt = ccsma_pkg::ST_DIV;
      end
      ccsma_pkg::ST_DIV: begin
        if (!fast_busy && !slow_busy) begin
          state_nxt = ccsma_pkg::ST_DONE;
        end
      end
      ccsma_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = ccsma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ccsma_pkg::ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Controller outputs. The result is loaded only when the output register
  // is empty or is being emptied in the same cycle.
  // -------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ccsma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ccsma_pkg::ST_READ: begin
        rd_en = (k_r != KW'(HIST_DEPTH));
      end
      ccsma_pkg::ST_START: begin
        div_start = 1'b1;
      end
      ccsma_pkg::ST_DIV: begin
      end
      ccsma_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: begin
      end
    endcase
  end

  assign in_accept     = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  // -------------------------------------------------------------------------
  // History RAM. The new close is written in the accept cycle; the sweep
  // starts in the next cycle, so a read never meets a write.
  // -------------------------------------------------------------------------
  ccsma_ram #(
    .WIDTH (ccsma_pkg::LEVEL_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (wptr_r),
    .wr_data (in_chan.close_level),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (hist_data)
  );

  // Only strictly positive closes in written slots take part.
  assign hist_pos  = !hist_data[ccsma_pkg::LEVEL_W-1] && (hist_data != '0);
  assign hist_live = rd_vld_r && hist_pos && (rd_k_r < fill_r);
  assign hist_val  = {{(SUM_W - POS_W){1'b0}}, hist_data[POS_W-1:0]};

  // -------------------------------------------------------------------------
  // Datapath.
  // -------------------------------------------------------------------------
  always_comb begin
    wptr_nxt     = wptr_r;
    rd_addr_nxt  = rd_addr_r;
    fill_nxt     = fill_r;
    k_nxt        = k_r;
    sum_fast_nxt = sum_fast_r;
    sum_slow_nxt = sum_slow_r;
    cnt_fast_nxt = cnt_fast_r;
    cnt_slow_nxt = cnt_slow_r;
    open_nxt     = open_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    close_nxt    = close_r;
    rd_vld_nxt   = rd_en;
    rd_k_nxt     = k_r;

    if (in_accept) begin
      wptr_nxt     = (wptr_r == AW'(HIST_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      rd_addr_nxt  = wptr_r;
      fill_nxt     = (fill_r == KW'(HIST_DEPTH)) ? fill_r : fill_r + 1'b1;
      k_nxt        = '0;
      sum_fast_nxt = '0;
      sum_slow_nxt = '0;
      cnt_fast_nxt = '0;
      cnt_slow_nxt = '0;
      open_nxt     = in_chan.open_level;
      high_nxt     = in_chan.high_level;
      low_nxt      = in_chan.low_level;
      close_nxt    = in_chan.close_level;
    end

    // Walk backwards from the newest slot, wrapping at the bottom.
    if (rd_en) begin
      k_nxt       = k_r + 1'b1;
      rd_addr_nxt = (rd_addr_r == '0) ? AW'(HIST_DEPTH - 1) : rd_addr_r - 1'b1;
    end

    if (hist_live) begin
      if (rd_k_r < KW'(FAST_WINDOW)) begin
        sum_fast_nxt = sum_fast_r + hist_val;
        cnt_fast_nxt = cnt_fast_r + 1'b1;
      end
      if (rd_k_r < KW'(SLOW_WINDOW)) begin
        sum_slow_nxt = sum_slow_r + hist_val;
        cnt_slow_nxt = cnt_slow_r + 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result. An empty window falls back to the current close.
  // -------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    high_byte_nxt  = high_byte_r;
    low_byte_nxt   = low_byte_r;
    open_byte_nxt  = open_byte_r;
    close_byte_nxt = close_byte_r;
    fast_avg_nxt   = fast_avg_r;
    slow_avg_nxt   = slow_avg_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      high_byte_nxt  = ccsma_pkg::clamp_byte(high_r);
      low_byte_nxt   = ccsma_pkg::clamp_byte(low_r);
      open_byte_nxt  = ccsma_pkg::clamp_byte(open_r);
      close_byte_nxt = ccsma_pkg::clamp_byte(close_r);
      fast_avg_nxt   = (cnt_fast_r == '0) ? ccsma_pkg::clamp_byte(close_r) : fast_q;
      slow_avg_nxt   = (cnt_slow_r == '0) ? ccsma_pkg::clamp_byte(close_r) : slow_q;
    end
  end

  // -------------------------------------------------------------------------
  // Dividers, one per window, started together once the sweep is over.
  // -------------------------------------------------------------------------
  ccsma_div #(
    .NUM_W (SUM_W),
    .DEN_W (KW)
  ) u_fast_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_fast_r),
    .den   (cnt_fast_r),
    .busy  (fast_busy),
    .quot  (fast_q)
  );

  ccsma_div #(
    .NUM_W (SUM_W),
    .DEN_W (KW)
  ) u_slow_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_slow_r),
    .den   (cnt_slow_r),
    .busy  (slow_busy),
    .quot  (slow_q)
  );

  // -------------------------------------------------------------------------
  // Registers.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccsma_pkg::ST_IDLE;
      wptr_r      <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      cnt_fast_r  <= '0;
      cnt_slow_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cnt_fast_r  <= cnt_fast_nxt;
      cnt_slow_r  <= cnt_slow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    rd_k_r       <= rd_k_nxt;
    sum_fast_r   <= sum_fast_nxt;
    sum_slow_r   <= sum_slow_nxt;
    open_r       <= open_nxt;
    high_r       <= high_nxt;
    low_r        <= low_nxt;
    close_r      <= close_nxt;
    high_byte_r  <= high_byte_nxt;
    low_byte_r   <= low_byte_nxt;
    open_byte_r  <= open_byte_nxt;
    close_byte_r <= close_byte_nxt;
    fast_avg_r   <= fast_avg_nxt;
    slow_avg_r   <= slow_avg_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.high_byte    = high_byte_r;
  assign out_chan.low_byte     = low_byte_r;
  assign out_chan.open_byte    = open_byte_r;
  assign out_chan.close_byte   = close_byte_r;
  assign out_chan.fast_average = fast_avg_r;
  assign out_chan.slow_average = slow_avg_r;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `CCSMA_ASSERT_IMPLY(a_no_rw_overlap, clk, rst_n, in_accept, !rd_en, "history read and write in one cycle")
  `CCSMA_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= KW'(HIST_DEPTH), "fill count beyond history depth")
  `CCSMA_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, (cnt_fast_r <= fill_r) && (cnt_slow_r <= fill_r), "window count exceeds written slots")
  `CCSMA_ASSERT_NEXT(a_accept_sweep, clk, rst_n, in_accept, (state_r == ccsma_pkg::ST_READ) && (k_r == '0), "sweep did not start after a request")
  `CCSMA_ASSERT_IMPLY(a_done_div_idle, clk, rst_n, state_r == ccsma_pkg::ST_DONE, !fast_busy && !slow_busy, "result taken while a divider runs")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Candle column with dual SMA: regression bench
// Sends candles through the valid/ready input channel and checks each result
// against an in-bench model of the clamp and of both moving averages.
// ---------------------------------------------------------------------------
module tb;

  import ccsma_pkg::*;

  // Timing of the run.
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 3;
  localparam int RAND_ITEMS    = 600;
  localparam int QUIET_ITEMS   = 100;
  localparam int HOLD_AT_ITEM  = 150;
  localparam int DRAIN_AT_ITEM = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;

  // The history in the model is deep enough for the larger of the two windows.
  localparam int HIST_DEPTH = (FAST_WINDOW_DEF > SLOW_WINDOW_DEF) ?
                              FAST_WINDOW_DEF : SLOW_WINDOW_DEF;
  localparam int DIR_ROWS   = 24;

  // One candle as it travels on the input channel.
  typedef struct packed {
    level_t open_level;
    level_t high_level;
    level_t low_level;
    level_t close_level;
  } candle_t;

  // One result as it travels on the output channel.
  typedef struct packed {
    byte_t high_byte;
    byte_t low_byte;
    byte_t open_byte;
    byte_t close_byte;
    byte_t fast_average;
    byte_t slow_average;
  } candle_bytes_t;

  // A row of the directed table. Where typed is set, the result is written
  // out by hand and checked as it stands; otherwise the model supplies it.
  typedef struct packed {
    candle_t       candle;
    logic          typed;
    candle_bytes_t result;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ccsma_in_if  in_chan ();
  ccsma_out_if out_chan ();

  candle_column_with_dual_sma_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Model state: the newest closes, newest first, and the results that are
  // owed by the block in the order the candles were accepted.
  level_t        close_hist [HIST_DEPTH];
  candle_bytes_t pending_candles [$];
  int            mismatch_count;

  // Control shared between the sender and the receiver.
  bit            hold_req;
  bit            quiet;

  // The directed table. The first rows start from the cleared history and use
  // the extremes of every field, so their results are plain to read. The rest
  // feed in a run of the largest close, walk through ordinary values
  // and finish with a long run of zero and negative closes, which empties the
  // fast window of positive closes while the slow one still holds some.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{16'sh8000, 16'sh7FFF, -16'sd1, 16'sh8000}, 1'b1,
      '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{'{16'sh7FFF, 16'sd255, 16'sd256, 16'sh7FFF}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
    '{'{16'sd255, 16'sd256, -16'sd256, 16'sh7FFF}, 1'b0, '0},
    '{'{-16'sd1, 16'sd0, 16'sd255, 16'sh7FFF}, 1'b0, '0},
    '{'{16'sd128, -16'sd128, 16'sd127, 16'sh7FFF}, 1'b0, '0},
    '{'{16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, '0},
    '{'{16'sd50, 16'sd60, 16'sd40, 16'sd50}, 1'b0, '0},
    '{'{16'sd60, 16'sd70, 16'sd50, 16'sd60}, 1'b0, '0},
    '{'{16'sd70, 16'sd80, 16'sd60, 16'sd70}, 1'b0, '0},
    '{'{16'sd255, 16'sd255, 16'sd255, 16'sd255}, 1'b0, '0},
    '{'{16'sd256, 16'sd256, 16'sd256, 16'sd256}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd100, -16'sd100, -16'sd100, -16'sd100}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd2, -16'sd2, -16'sd2, -16'sd2}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd3, -16'sd3, -16'sd3, -16'sd3}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd4, 16'sd5, -16'sd4, -16'sd4}, 1'b0, '0}
  };

  // Free-running clock.
  initial begin
    clk = 1'b0;
  end

  always #CLK_HALF clk = ~clk;

  // Saturates a signed value to the byte range.
  function automatic byte_t sat_int(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > BYTE_MAX) begin
      return 8'd255;
    end
    return byte_t'(v);
  endfunction

  // Mean of the positive closes among the newest win entries. With none to
  // count, the current close stands in, which then saturates to zero.
  function automatic byte_t window_mean(input int win, input level_t current);
    int unsigned sum;
    int unsigned cnt;
    int          k;
    sum = 0;
    cnt = 0;
    for (k = 0; k < win && k < HIST_DEPTH; k++) begin
      if (close_hist[k] > 0) begin
        sum += int'(close_hist[k]);
        cnt++;
      end
    end
    if (cnt == 0) begin
      return sat_int(int'(current));
    end
    return sat_int(int'(sum / cnt));
  endfunction

  // Pushes the close into the history and works out the full result.
  function automatic candle_bytes_t predict_candle(input candle_t c);
    candle_bytes_t r;
    int            k;
    for (k = HIST_DEPTH - 1; k > 0; k--) begin
      close_hist[k] = close_hist[k-1];
    end
    close_hist[0]  = c.close_level;
    r.high_byte    = sat_int(int'(c.high_level));
    r.low_byte     = sat_int(int'(c.low_level));
    r.open_byte    = sat_int(int'(c.open_level));
    r.close_byte   = sat_int(int'(c.close_level));
    r.fast_average = window_mean(FAST_WINDOW_DEF, c.close_level);
    r.slow_average = window_mean(SLOW_WINDOW_DEF, c.close_level);
    return r;
  endfunction

  // Random open, high or low level: half of them near the clamp boundaries,
  // the other half over the whole 16-bit range.
  function automatic level_t rand_level();
    if ($urandom_range(0, 1) == 0) begin
      return level_t'(int'($urandom_range(0, 350)) - 50);
    end
    return level_t'($urandom);
  endfunction

  // Random close. Most closes are positive and in the byte range, so that the
  // averages carry real content; the rest are large, zero, negative, on the
  // clamp edges or wholly random.
  function automatic level_t rand_close();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return level_t'($urandom_range(1, 255));
      4:          return level_t'($urandom_range(256, 32767));
      5:          return 16'sd0;
      6:          return level_t'(0 - int'($urandom_range(1, 300)));
      7:          return level_t'($urandom);
      8:          return ($urandom_range(0, 1) == 0) ? 16'sd1 : 16'sd255;
      default:    return level_t'($urandom_range(200, 300));
    endcase
  endfunction

  // Offers one candle and holds the request until the block takes it. The
  // model runs at the edge of acceptance; a typed result from the table
  // overrides the model's, while the model still tracks the history.
  task automatic offer_candle(input candle_t c, input logic typed,
                              input candle_bytes_t typed_res);
    candle_bytes_t exp_res;
    in_chan.valid       <= 1'b1;
    in_chan.open_level  <= c.open_level;
    in_chan.high_level  <= c.high_level;
    in_chan.low_level   <= c.low_level;
    in_chan.close_level <= c.close_level;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    exp_res = predict_candle(c);
    if (typed) begin
      exp_res = typed_res;
    end
    pending_candles.push_back(exp_res);
  endtask

  // After each accepted request the sender may drop valid for a burst of
  // idle cycles. Only one assignment to valid falls in any time step: either
  // it is lowered here, or the next offer raises it again.
  task automatic sender_gap();
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: reset, the directed table, then random candles, then drain.
  initial begin
    candle_t c;
    int      i;
    mismatch_count = 0;
    hold_req       = 1'b0;
    quiet          = 1'b0;
    for (i = 0; i < HIST_DEPTH; i++) begin
      close_hist[i] = '0;
    end
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.open_level  <= '0;
    in_chan.high_level  <= '0;
    in_chan.low_level   <= '0;
    in_chan.close_level <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      offer_candle(dir_table[i].candle, dir_table[i].typed, dir_table[i].result);
      sender_gap();
    end

    for (i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= RAND_ITEMS - QUIET_ITEMS);
      // Ask the receiver for a long hold-off. The sender keeps offering, so
      // the output register fills, the next candle finishes behind it and
      // the input channel stalls.
      if (i == HOLD_AT_ITEM) begin
        hold_req = 1'b1;
      end
      // Let the block run dry once, with the input quiet until every result
      // owed has come out.
      if (i == DRAIN_AT_ITEM) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending_candles.size() != 0) begin
          @(posedge clk);
        end
      end
      c.open_level  = rand_level();
      c.high_level  = rand_level();
      c.low_level   = rand_level();
      c.close_level = rand_close();
      offer_candle(c, 1'b0, '0);
      sender_gap();
    end
    in_chan.valid <= 1'b0;

    // Wait for every result, then a little longer in case the block emits
    // something it should not.
    while (pending_candles.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: checks every accepted result against the oldest one owed and
  // then decides the ready level for the next cycle. Ready drops in random
  // bursts, for the long hold-off when it is asked for, and never in the
  // quiet part at the end.
  initial begin
    candle_bytes_t got;
    candle_bytes_t exp_res;
    int            hold_left;
    int            idle_left;
    logic          next_ready;
    hold_left = 0;
    idle_left = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        next_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle_left  = $urandom_range(1, 11) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_chan.ready <= next_ready;
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.high_byte, out_chan.low_byte, out_chan.open_byte,
                out_chan.close_byte, out_chan.fast_average, out_chan.slow_average};
        if (pending_candles.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hi=%0d lo=%0d op=%0d cl=%0d fast=%0d slow=%0d",
                   $time, got.high_byte, got.low_byte, got.open_byte,
                   got.close_byte, got.fast_average, got.slow_average);
          mismatch_count++;
        end else begin
          exp_res = pending_candles.pop_front();
          if (got !== exp_res) begin
            $display("%0t: result mismatch, expected hi=%0d lo=%0d op=%0d cl=%0d fast=%0d slow=%0d, actual hi=%0d lo=%0d op=%0d cl=%0d fast=%0d slow=%0d",
                     $time, exp_res.high_byte, exp_res.low_byte, exp_res.open_byte,
                     exp_res.close_byte, exp_res.fast_average, exp_res.slow_average,
                     got.high_byte, got.low_byte, got.open_byte,
                     got.close_byte, got.fast_average, got.slow_average);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles with no request moving on either channel. The
  // limit sits well above the long hold-off and the per-candle time.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ===== candle_column_with_dual_sma_core.f =====
+incdir+rtl
rtl/ccsma_pkg.sv
rtl/ccsma_in_if.sv
rtl/ccsma_out_if.sv
rtl/ccsma_ram.sv
rtl/ccsma_div.sv
rtl/candle_column_with_dual_sma_core.sv
tb/sv/tb.sv
